// File: rtl/core/sve_pkg.sv
// Shared types, opcodes and sizing constants for the script VM execute unit.
// No dependencies; every other file of the block except sve_if imports this package.
`timescale 1ns / 1ps

package sve_pkg;

	localparam int STACK_WORDS    = 256;
	localparam int CALLBACK_SLOTS = 8;
	localparam int REGISTER_COUNT = 16;

	localparam int SW_AW = $clog2(STACK_WORDS);
	localparam int CB_AW = (CALLBACK_SLOTS > 1) ? $clog2(CALLBACK_SLOTS) : 1;

	// words moved by a callback frame: all registers, the flags and the pc
	localparam int FRAME_WORDS = REGISTER_COUNT + 2;
	localparam logic [4:0] FRAME_LAST = 5'(FRAME_WORDS - 1);
	localparam logic [4:0] FRAME_FLAGS_POS = 5'(REGISTER_COUNT);

	localparam logic [3:0]  CURSOR_REG      = 4'd15;
	localparam logic [15:0] FLAG_CLEAR_MASK = 16'hFFFE;
	localparam logic [31:0] STACK_STEP      = 32'd4;

	typedef enum logic [5:0] {
		OP_JUMP, OP_JZ, OP_CALL, OP_RET, OP_COPY, OP_SETI, OP_PUSH, OP_PUSHI, OP_POP,
		OP_ADD, OP_ADDI, OP_SUB, OP_SUBI, OP_MUL, OP_MULI, OP_INC, OP_DEC, OP_NEG,
		OP_AND, OP_ANDI, OP_OR, OP_ORI, OP_XOR, OP_DIV, OP_DIVI, OP_MOD, OP_MODI,
		OP_XORI, OP_NOT, OP_LAND, OP_LANDI, OP_LOR, OP_LORI, OP_LNOT, OP_SIGN, OP_LEZ,
		OP_GTZ, OP_GEZ, OP_EQZ, OP_NEZ, OP_SETCB, OP_RUNCB, OP_JMPR, OP_RESTORE,
		OP_CLRFLAG, OP_SETFLAG, OP_FAIL
	} op_t;

	typedef enum logic [2:0] {
		CL_EXEC, CL_DIV, CL_PUSH, CL_POP, CL_RUNCB, CL_RESTORE
	} op_class_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_RDD, ST_RDS, ST_DISP, ST_DIV, ST_POPWB,
		ST_CBPUSH, ST_RSRD, ST_RSWB, ST_FIN
	} state_t;

	typedef enum logic [1:0] {
		PS_OPER, PS_RF, PS_FLAGS, PS_PC
	} push_sel_t;

	// controller to datapath commands
	typedef struct packed {
		logic      load;
		logic      ld_dv;
		logic      ld_sv;
		logic      rd_cnt;
		logic      exec;
		logic      div_start;
		logic      push;
		push_sel_t push_sel;
		logic      pop_rd;
		logic      rs_wb;
		logic      cb_enter;
		logic      finish;
		logic [4:0] cnt;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		op_class_t cls;
		logic      div_zero;
		logic      cb_live;
		logic      div_done;
		logic      out_full;
	} stat_t;

	function automatic op_class_t op_class(input logic [5:0] f);
		op_class_t c;
		case (f)
			OP_DIV, OP_DIVI, OP_MOD, OP_MODI: c = CL_DIV;
			OP_PUSH, OP_PUSHI, OP_CALL:       c = CL_PUSH;
			OP_POP, OP_RET:                   c = CL_POP;
			OP_RUNCB:                         c = CL_RUNCB;
			OP_RESTORE:                       c = CL_RESTORE;
			default:                          c = CL_EXEC;
		endcase
		return c;
	endfunction

endpackage

// File: rtl/core/sve_if.sv
// Valid/ready channel interfaces for instruction items and result items.
// Depends on nothing.
`timescale 1ns / 1ps

interface sve_in_if;
	logic        valid;
	logic        ready;
	logic [5:0]  func;
	logic [3:0]  dst;
	logic [3:0]  src;
	logic [31:0] imm;
	logic [2:0]  instr_len;
	modport source (output valid, func, dst, src, imm, instr_len, input ready);
	modport sink (input valid, func, dst, src, imm, instr_len, output ready);
endinterface

interface sve_out_if;
	logic               valid;
	logic               ready;
	logic [31:0]        next_pc;
	logic               status;
	logic signed [31:0] written_value;
	logic               wrote_register;
	modport source (output valid, next_pc, status, written_value, wrote_register, input ready);
	modport sink (input valid, next_pc, status, written_value, wrote_register, output ready);
endinterface

// File: rtl/core/sve_div.sv
// Iterative signed divider, one quotient bit per cycle, truncating.
// Depends on sve_pkg.
`timescale 1ns / 1ps

module sve_div
	import sve_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        want_rem,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic        done,
	output logic [31:0] result
);

	logic        busy_q, done_q, na_q, nb_q, rem_sel_q;
	logic [4:0]  cnt_q;
	logic [31:0] quo_q, rem_q, den_q;
	logic [32:0] trial;
	logic [32:0] diff;

	// one restoring step: shift in the next dividend bit and try a subtract
	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// operand magnitudes at start, then the shift/subtract loop
	always_ff @(posedge clk) begin
		if (start) begin
			na_q      <= a[31];
			nb_q      <= b[31];
			rem_sel_q <= want_rem;
			quo_q     <= a[31] ? (32'd0 - a) : a;
			den_q     <= b[31] ? (32'd0 - b) : b;
			rem_q     <= '0;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	// apply signs: remainder follows the dividend
	always_comb begin
		if (rem_sel_q)
			result = na_q ? (32'd0 - rem_q) : rem_q;
		else
			result = (na_q != nb_q) ? (32'd0 - quo_q) : quo_q;
	end

	assign done = done_q;

endmodule

// File: rtl/core/sve_dpath.sv
// Datapath: pc, register file, stack memory, callback slots, flags, ALU and output register.
// Depends on sve_pkg and sve_div.
`timescale 1ns / 1ps

module sve_dpath
	import sve_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output stat_t              stat,
	input  logic [5:0]         func,
	input  logic [3:0]         dst,
	input  logic [3:0]         src,
	input  logic [31:0]        imm,
	input  logic [2:0]         instr_len,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        next_pc,
	output logic               status,
	output logic signed [31:0] written_value,
	output logic               wrote_register
);

	logic [5:0]  func_q;
	logic [3:0]  dst_q, src_q;
	logic [31:0] imm_q;
	logic [31:0] pc_q, dv_q, sv_q, mem_q;
	logic [31:0] rf_q [REGISTER_COUNT];
	logic [31:0] cb_q [CALLBACK_SLOTS];
	logic [15:0] flags_q;
	logic [31:0] res_q;
	logic        wr_q, fail_q;
	logic        out_valid_q;
	logic [31:0] out_pc_q, out_res_q;
	logic        out_fail_q, out_wr_q;

	logic [31:0] stack_mem [STACK_WORDS];

	logic [3:0]       rd_addr;
	logic [31:0]      rf_rd, cursor, push_cur, push_val, divisor, cb_val, mul_b, prod, div_res;
	logic [SW_AW-1:0] push_idx, pop_idx;
	logic             cb_in_range, div_done;
	logic [31:0]      e_res, e_pc;
	logic             e_wr, e_fail;
	logic [3:0]       rs_reg;

	// single register read port
	always_comb begin
		if (cmd.rd_cnt)
			rd_addr = cmd.cnt[3:0];
		else if (cmd.ld_sv)
			rd_addr = src_q;
		else
			rd_addr = dst_q;
	end
	assign rf_rd = rf_q[rd_addr];

	// stack addressing from the cursor register
	assign cursor   = rf_q[CURSOR_REG];
	assign push_cur = cursor - STACK_STEP;
	assign push_idx = push_cur[SW_AW+1:2];
	assign pop_idx  = cursor[SW_AW+1:2];

	always_comb begin
		case (cmd.push_sel)
			PS_RF:    push_val = rf_rd;
			PS_FLAGS: push_val = {16'd0, flags_q};
			PS_PC:    push_val = pc_q;
			default: begin
				if (func_q == OP_CALL)
					push_val = pc_q;
				else if (func_q == OP_PUSHI)
					push_val = imm_q;
				else
					push_val = dv_q;
			end
		endcase
	end

	assign cb_in_range = int'(dst_q) < CALLBACK_SLOTS;
	assign cb_val      = cb_in_range ? cb_q[CB_AW'(dst_q)] : 32'd0;

	assign divisor = (func_q == OP_DIVI || func_q == OP_MODI) ? imm_q : sv_q;
	assign mul_b   = (func_q == OP_MULI) ? imm_q : sv_q;
	assign prod    = dv_q * mul_b;

	sve_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.want_rem (func_q == OP_MOD || func_q == OP_MODI),
		.a        (dv_q),
		.b        (divisor),
		.done     (div_done),
		.result   (div_res)
	);

	// combinational result, write and fail decode for each operation; divides use the divider result
	always_comb begin
		e_res  = '0;
		e_wr   = 1'b1;
		e_fail = 1'b0;
		e_pc   = pc_q;
		case (func_q)
			OP_JUMP:  begin e_wr = 1'b0; e_pc = imm_q; end
			OP_JZ:    begin e_wr = 1'b0; if (dv_q == 32'd0) e_pc = imm_q; end
			OP_CALL:  begin e_wr = 1'b0; e_pc = imm_q; end
			OP_RET:   begin e_wr = 1'b0; e_pc = mem_q; end
			OP_COPY:  e_res = sv_q;
			OP_SETI:  e_res = imm_q;
			OP_PUSH, OP_PUSHI, OP_SETCB, OP_RUNCB, OP_RESTORE, OP_CLRFLAG, OP_SETFLAG:
				e_wr = 1'b0;
			OP_POP:   e_res = mem_q;
			OP_ADD:   e_res = dv_q + sv_q;
			OP_ADDI:  e_res = dv_q + imm_q;
			OP_SUB:   e_res = dv_q - sv_q;
			OP_SUBI:  e_res = dv_q - imm_q;
			OP_MUL, OP_MULI: e_res = prod;
			OP_INC:   e_res = dv_q + 32'd1;
			OP_DEC:   e_res = dv_q - 32'd1;
			OP_NEG:   e_res = 32'd0 - dv_q;
			OP_AND:   e_res = dv_q & sv_q;
			OP_ANDI:  e_res = dv_q & imm_q;
			OP_OR:    e_res = dv_q | sv_q;
			OP_ORI:   e_res = dv_q | imm_q;
			OP_XOR:   e_res = dv_q ^ sv_q;
			OP_XORI:  e_res = dv_q ^ imm_q;
			OP_DIV, OP_DIVI, OP_MOD, OP_MODI: begin
				if (divisor == 32'd0) begin
					e_wr   = 1'b0;
					e_fail = 1'b1;
				end else begin
					e_res = div_res;
				end
			end
			OP_NOT:   e_res = ~dv_q;
			OP_LAND:  e_res = {31'd0, (dv_q != 32'd0) && (sv_q != 32'd0)};
			OP_LANDI: e_res = {31'd0, (dv_q != 32'd0) && (imm_q != 32'd0)};
			OP_LOR:   e_res = {31'd0, (dv_q != 32'd0) || (sv_q != 32'd0)};
			OP_LORI:  e_res = {31'd0, (dv_q != 32'd0) || (imm_q != 32'd0)};
			OP_LNOT, OP_EQZ: e_res = {31'd0, dv_q == 32'd0};
			OP_SIGN:  e_res = {31'd0, dv_q[31]};
			OP_LEZ:   e_res = {31'd0, dv_q[31] || (dv_q == 32'd0)};
			OP_GTZ:   e_res = {31'd0, !dv_q[31] && (dv_q != 32'd0)};
			OP_GEZ:   e_res = {31'd0, !dv_q[31]};
			OP_NEZ:   e_res = {31'd0, dv_q != 32'd0};
			OP_JMPR:  begin e_wr = 1'b0; e_pc = pc_q + {16'd0, imm_q[15:0]}; end
			default:  begin e_wr = 1'b0; e_fail = 1'b1; end
		endcase
	end

	// restore writes r15 first, down to r0
	assign rs_reg = 4'(FRAME_LAST - cmd.cnt);

	// latch the instruction and the operand values read from the register file
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= func;
			dst_q  <= dst;
			src_q  <= src;
			imm_q  <= imm;
		end
		if (cmd.ld_dv)
			dv_q <= rf_rd;
		if (cmd.ld_sv)
			sv_q <= rf_rd;
	end

	// architectural state; a load advances the pc by the instruction length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q    <= '0;
			flags_q <= '0;
			for (int i = 0; i < REGISTER_COUNT; i++)
				rf_q[i] <= '0;
			for (int i = 0; i < CALLBACK_SLOTS; i++)
				cb_q[i] <= '0;
			res_q   <= '0;
			wr_q    <= 1'b0;
			fail_q  <= 1'b0;
		end else begin
			if (cmd.load) begin
				pc_q   <= pc_q + {29'd0, instr_len};
				res_q  <= '0;
				wr_q   <= 1'b0;
				fail_q <= 1'b0;
			end
			if (cmd.push)
				rf_q[CURSOR_REG] <= push_cur;
			if (cmd.pop_rd)
				rf_q[CURSOR_REG] <= cursor + STACK_STEP;
			if (cmd.exec) begin
				pc_q   <= e_pc;
				res_q  <= e_wr ? e_res : 32'd0;
				wr_q   <= e_wr;
				fail_q <= e_fail;
				if (e_wr)
					rf_q[dst_q] <= e_res;
				if (func_q == OP_SETCB && cb_in_range)
					cb_q[CB_AW'(dst_q)] <= imm_q;
				if (func_q == OP_CLRFLAG)
					flags_q <= flags_q & FLAG_CLEAR_MASK;
				if (func_q == OP_SETFLAG)
					flags_q <= flags_q | 16'd1;
			end
			if (cmd.cb_enter) begin
				flags_q <= flags_q | 16'd1;
				pc_q    <= cb_val;
			end
			if (cmd.rs_wb) begin
				if (cmd.cnt == 5'd0)
					pc_q <= mem_q;
				else if (cmd.cnt == 5'd1)
					flags_q <= mem_q[15:0];
				else
					rf_q[rs_reg] <= mem_q;
			end
		end
	end

	// stack memory with registered read
	always_ff @(posedge clk) begin
		if (cmd.push)
			stack_mem[push_idx] <= push_val;
		if (cmd.pop_rd)
			mem_q <= stack_mem[pop_idx];
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.finish)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_pc_q   <= pc_q;
			out_fail_q <= fail_q;
			out_res_q  <= res_q;
			out_wr_q   <= wr_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign next_pc        = out_pc_q;
	assign status         = out_fail_q;
	assign written_value  = out_res_q;
	assign wrote_register = out_wr_q;

	assign stat.cls      = op_class(func_q);
	assign stat.div_zero = (divisor == 32'd0);
	assign stat.cb_live  = (cb_val != 32'd0);
	assign stat.div_done = div_done;
	assign stat.out_full = out_valid_q && !out_ready;

endmodule

// File: rtl/core/sve_ctrl.sv
// Controller state machine: sequences operand reads, execution, divide, stack frames.
// Depends on sve_pkg.
`timescale 1ns / 1ps

module sve_ctrl
	import sve_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	state_t     state_q, state_d;
	logic [4:0] cnt_q, cnt_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.push_sel = PS_OPER;
		cmd.cnt  = cnt_q;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_RDD;
				end
			end
			ST_RDD: begin
				cmd.ld_dv = 1'b1;
				state_d   = ST_RDS;
			end
			ST_RDS: begin
				cmd.ld_sv = 1'b1;
				state_d   = ST_DISP;
			end
			ST_DISP: begin
				case (stat.cls)
					CL_DIV: begin
						if (stat.div_zero) begin
							cmd.exec = 1'b1;
							state_d  = ST_FIN;
						end else begin
							cmd.div_start = 1'b1;
							state_d       = ST_DIV;
						end
					end
					CL_PUSH: begin
						cmd.push = 1'b1;
						cmd.exec = 1'b1;
						state_d  = ST_FIN;
					end
					CL_POP: begin
						cmd.pop_rd = 1'b1;
						state_d    = ST_POPWB;
					end
					CL_RUNCB: begin
						cnt_d   = '0;
						state_d = stat.cb_live ? ST_CBPUSH : ST_FIN;
					end
					CL_RESTORE: begin
						cnt_d   = '0;
						state_d = ST_RSRD;
					end
					default: begin
						cmd.exec = 1'b1;
						state_d  = ST_FIN;
					end
				endcase
			end
			// hold until the divider delivers
			ST_DIV: begin
				if (stat.div_done) begin
					cmd.exec = 1'b1;
					state_d  = ST_FIN;
				end
			end
			ST_POPWB: begin
				cmd.exec = 1'b1;
				state_d  = ST_FIN;
			end
			// push registers, then flags, then pc; enter the callback on the last word
			ST_CBPUSH: begin
				cmd.push   = 1'b1;
				cmd.rd_cnt = 1'b1;
				if (cnt_q == FRAME_LAST)
					cmd.push_sel = PS_PC;
				else if (cnt_q == FRAME_FLAGS_POS)
					cmd.push_sel = PS_FLAGS;
				else
					cmd.push_sel = PS_RF;
				if (cnt_q == FRAME_LAST) begin
					cmd.cb_enter = 1'b1;
					state_d      = ST_FIN;
				end else begin
					cnt_d = cnt_q + 5'd1;
				end
			end
			ST_RSRD: begin
				cmd.pop_rd = 1'b1;
				state_d    = ST_RSWB;
			end
			ST_RSWB: begin
				cmd.rs_wb = 1'b1;
				if (cnt_q == FRAME_LAST) begin
					state_d = ST_FIN;
				end else begin
					cnt_d   = cnt_q + 5'd1;
					state_d = ST_RSRD;
				end
			end
			// wait for room in the output register
			ST_FIN: begin
				if (!stat.out_full) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// File: rtl/core/script_vm_execute_unit.sv
// Top level of the script VM execute unit: controller, datapath and channel ports.
// Depends on sve_pkg, sve_if, sve_ctrl and sve_dpath.
`timescale 1ns / 1ps

// Executes one decoded script instruction per input transaction and returns one
// result transaction with the new pc, a fail status and the destination write.
// One instruction is in flight at a time. After acceptance the unit reads the
// destination and then the source register and dispatches: plain ALU, jump and
// push operations and an empty callback run execute at dispatch, pop and return
// first take a registered memory read, divide and modulo by a nonzero divisor
// wait for the 32-step bit-serial divider, a callback run makes 18 stack writes
// through the single memory port and a frame restore makes 18 registered memory
// reads, each written back. A new instruction is accepted in the cycle after the
// result is loaded, even while that result still waits at the output. Reset
// clears registers, callback slots, flags and pc at once, but not stack memory.

module script_vm_execute_unit
	import sve_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	sve_in_if.sink    in_ch,
	sve_out_if.source out_ch
);

	cmd_t  cmd;
	stat_t stat;

	sve_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	sve_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.func           (in_ch.func),
		.dst            (in_ch.dst),
		.src            (in_ch.src),
		.imm            (in_ch.imm),
		.instr_len      (in_ch.instr_len),
		.out_valid      (out_ch.valid),
		.out_ready      (out_ch.ready),
		.next_pc        (out_ch.next_pc),
		.status         (out_ch.status),
		.written_value  (out_ch.written_value),
		.wrote_register (out_ch.wrote_register)
	);

	// one instruction at a time: no accept right after an accept
	a_single_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(in_ch.valid && in_ch.ready) |=> !in_ch.ready)
		else $error("input accepted while an instruction is in flight");

	// a result without a register write carries zero
	a_zero_when_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.wrote_register) |-> (out_ch.written_value == 32'sd0))
		else $error("nonzero written_value without a register write");

	// a failing instruction never writes its destination
	a_fail_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status) |-> !out_ch.wrote_register)
		else $error("failed instruction reported a register write");

	// the output register is only loaded when it has room
	a_finish_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> !(out_ch.valid && !out_ch.ready))
		else $error("result loaded over a pending result");

endmodule

// File: bench/sve_checker.sv
// Scoreboard for the script VM execute unit: watches both channels, predicts each result.
// Depends on sve_pkg and the channel interfaces in sve_if.
`timescale 1ns / 1ps

module sve_checker
	import sve_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	sve_in_if    in_ch,
	sve_out_if   out_ch,
	output int   fail_count,
	output int   pending,
	output int   retired
);

	typedef struct packed {
		logic [31:0] next_pc;
		logic        status;
		logic [31:0] value;
		logic        wrote;
	} retire_t;

	retire_t     pending_results[$];
	logic [31:0] pc;
	logic [31:0] regs [REGISTER_COUNT];
	logic [31:0] stack_mem [STACK_WORDS];
	logic [31:0] cb_slot [CALLBACK_SLOTS];
	logic [15:0] flags;

	assign pending = pending_results.size();

	// signed truncating divide; remainder takes the dividend's sign
	function automatic logic [31:0] signed_divmod(logic [31:0] a, logic [31:0] b, bit want_rem);
		logic [31:0] ma, mb, q, r;
		ma = a[31] ? -a : a;
		mb = b[31] ? -b : b;
		q = ma / mb;
		r = ma % mb;
		if (want_rem) begin
			return a[31] ? -r : r;
		end
		return (a[31] ^ b[31]) ? -q : q;
	endfunction

	task automatic push_stack(logic [31:0] v);
		regs[CURSOR_REG] = regs[CURSOR_REG] - STACK_STEP;
		stack_mem[(regs[CURSOR_REG] >> 2) % STACK_WORDS] = v;
	endtask

	task automatic pop_stack(output logic [31:0] v);
		v = stack_mem[(regs[CURSOR_REG] >> 2) % STACK_WORDS];
		regs[CURSOR_REG] = regs[CURSOR_REG] + STACK_STEP;
	endtask

	// apply one instruction to the shadow state and return its result
	task automatic execute_instr(logic [5:0] func, logic [3:0] d, logic [3:0] s,
			logic [31:0] imm, logic [2:0] len, output retire_t r);
		logic [31:0] dv, sv, res, tgt, w;
		bit wr, fail;
		dv = regs[d];
		sv = regs[s];
		res = '0;
		wr = 0;
		fail = 0;
		pc = pc + 32'(len);
		case (func)
			OP_JUMP:    pc = imm;
			OP_JZ:      if (dv == 0) pc = imm;
			OP_CALL: begin
				push_stack(pc);
				pc = imm;
			end
			OP_RET:     pop_stack(pc);
			OP_COPY:    begin res = sv; wr = 1; end
			OP_SETI:    begin res = imm; wr = 1; end
			OP_PUSH:    push_stack(dv);
			OP_PUSHI:   push_stack(imm);
			OP_POP:     begin pop_stack(res); wr = 1; end
			OP_ADD:     begin res = dv + sv; wr = 1; end
			OP_ADDI:    begin res = dv + imm; wr = 1; end
			OP_SUB:     begin res = dv - sv; wr = 1; end
			OP_SUBI:    begin res = dv - imm; wr = 1; end
			OP_MUL:     begin res = dv * sv; wr = 1; end
			OP_MULI:    begin res = dv * imm; wr = 1; end
			OP_INC:     begin res = dv + 1; wr = 1; end
			OP_DEC:     begin res = dv - 1; wr = 1; end
			OP_NEG:     begin res = -dv; wr = 1; end
			OP_AND:     begin res = dv & sv; wr = 1; end
			OP_ANDI:    begin res = dv & imm; wr = 1; end
			OP_OR:      begin res = dv | sv; wr = 1; end
			OP_ORI:     begin res = dv | imm; wr = 1; end
			OP_XOR:     begin res = dv ^ sv; wr = 1; end
			OP_DIV, OP_MOD: begin
				if (sv == 0) fail = 1;
				else begin res = signed_divmod(dv, sv, func == OP_MOD); wr = 1; end
			end
			OP_DIVI, OP_MODI: begin
				if (imm == 0) fail = 1;
				else begin res = signed_divmod(dv, imm, func == OP_MODI); wr = 1; end
			end
			OP_XORI:    begin res = dv ^ imm; wr = 1; end
			OP_NOT:     begin res = ~dv; wr = 1; end
			OP_LAND:    begin res = 32'(dv != 0 && sv != 0); wr = 1; end
			OP_LANDI:   begin res = 32'(dv != 0 && imm != 0); wr = 1; end
			OP_LOR:     begin res = 32'(dv != 0 || sv != 0); wr = 1; end
			OP_LORI:    begin res = 32'(dv != 0 || imm != 0); wr = 1; end
			OP_LNOT:    begin res = 32'(dv == 0); wr = 1; end
			OP_SIGN:    begin res = 32'(dv[31]); wr = 1; end
			OP_LEZ:     begin res = 32'(dv[31] || dv == 0); wr = 1; end
			OP_GTZ:     begin res = 32'(!dv[31] && dv != 0); wr = 1; end
			OP_GEZ:     begin res = 32'(!dv[31]); wr = 1; end
			OP_EQZ:     begin res = 32'(dv == 0); wr = 1; end
			OP_NEZ:     begin res = 32'(dv != 0); wr = 1; end
			OP_SETCB:   if (d < CALLBACK_SLOTS) cb_slot[d] = imm;
			OP_RUNCB: begin
				tgt = (d < CALLBACK_SLOTS) ? cb_slot[d] : '0;
				if (tgt != 0) begin
					for (int i = 0; i < REGISTER_COUNT; i++) push_stack(regs[i]);
					push_stack({16'h0, flags});
					push_stack(pc);
					flags[0] = 1'b1;
					pc = tgt;
				end
			end
			OP_JMPR:    pc = pc + {16'h0, imm[15:0]};
			OP_RESTORE: begin
				pop_stack(tgt);
				pop_stack(w);
				flags = w[15:0];
				for (int i = REGISTER_COUNT - 1; i >= 0; i--) begin
					pop_stack(w);
					regs[i] = w;
				end
				pc = tgt;
			end
			OP_CLRFLAG: flags = flags & FLAG_CLEAR_MASK;
			OP_SETFLAG: flags[0] = 1'b1;
			default:    fail = 1;
		endcase
		if (wr) regs[d] = res;
		else res = '0;
		r = '{next_pc: pc, status: fail, value: res, wrote: wr};
	endtask

	// predict on each accepted instruction, compare each accepted result
	always @(posedge clk or negedge arst_n) begin
		retire_t exp_r, got;
		if (!arst_n) begin
			pc = '0;
			flags = '0;
			for (int i = 0; i < REGISTER_COUNT; i++) regs[i] = '0;
			for (int i = 0; i < CALLBACK_SLOTS; i++) cb_slot[i] = '0;
			pending_results.delete();
			fail_count = 0;
			retired = 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				execute_instr(in_ch.func, in_ch.dst, in_ch.src, in_ch.imm, in_ch.instr_len, exp_r);
				pending_results.push_back(exp_r);
			end
			if (out_ch.valid && out_ch.ready) begin
				got = '{next_pc: out_ch.next_pc, status: out_ch.status,
					value: out_ch.written_value, wrote: out_ch.wrote_register};
				retired++;
				if (pending_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10) $display("unexpected result transaction: %p", got);
				end else begin
					exp_r = pending_results.pop_front();
					if (got !== exp_r) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result %0d mismatch: expected pc=%h st=%b val=%h wr=%b, got pc=%h st=%b val=%h wr=%b",
								retired, exp_r.next_pc, exp_r.status, exp_r.value, exp_r.wrote,
								got.next_pc, got.status, got.value, got.wrote);
					end
				end
			end
		end
	end

endmodule

// File: bench/tb_top.sv
// Stimulus and verdict for the script VM execute unit; instantiates the block and sve_checker.
// Depends on sve_pkg, sve_if, script_vm_execute_unit and sve_checker.
`timescale 1ns / 1ps

module tb_top;
	import sve_pkg::*;

	localparam int RANDOM_ITEMS = 1900;
	localparam logic [5:0] FIRST_UNDEF_OP = 6'(OP_FAIL) + 6'd1;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit   hold_off = 0;
	int   sent = 0;
	int   fail_count, pending, retired;

	sve_in_if  in_ch ();
	sve_out_if out_ch ();

	script_vm_execute_unit dut (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch));
	sve_checker chk (.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.fail_count(fail_count), .pending(pending), .retired(retired));

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	initial begin
		in_ch.valid = 1'b0;
		in_ch.func = '0;
		in_ch.dst = '0;
		in_ch.src = '0;
		in_ch.imm = '0;
		in_ch.instr_len = 3'd1;
		out_ch.ready = 1'b0;
	end

	// idle length: mostly short, now and then long
	function automatic int idle_len();
		if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
		return $urandom_range(0, 3);
	endfunction

	// result side: random stalls, or a long hold while hold_off is set
	initial begin
		int stall;
		bit steady;
		stall = 0;
		steady = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0) steady = !steady;
			if (hold_off) begin
				out_ch.ready <= 1'b0;
			end else if (stall > 0) begin
				stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (!steady && $urandom_range(0, 3) == 0) stall = idle_len();
			end
		end
	end

	// hold off the result side once so the block backs up into its input
	initial begin
		wait (sent >= 700);
		@(posedge clk);
		hold_off = 1;
		repeat (400) @(posedge clk);
		hold_off = 0;
	end

	bit steady_in = 0;

	// offer one instruction and hold it until accepted; called at a rising edge
	task automatic issue(logic [5:0] func, logic [3:0] d, logic [3:0] s, logic [31:0] imm,
			logic [2:0] len = 3'($urandom_range(1, 6)));
		int gap;
		in_ch.valid <= 1'b1;
		in_ch.func <= func;
		in_ch.dst <= d;
		in_ch.src <= s;
		in_ch.imm <= imm;
		in_ch.instr_len <= len;
		@(negedge clk);
		while (!in_ch.ready) @(negedge clk);
		@(posedge clk);
		sent++;
		if ($urandom_range(0, 199) == 0) steady_in = !steady_in;
		gap = steady_in ? 0 : ($urandom_range(0, 2) == 0 ? idle_len() : 0);
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	function automatic logic [31:0] edge_word();
		case ($urandom_range(0, 5))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return 32'h1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [3:0] rreg();
		return 4'($urandom_range(0, 15));
	endfunction

	// random instruction mix, biased toward stack frames that reach deep state
	task automatic random_instr();
		int pick, n;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			issue(OP_SETI, rreg(), rreg(), edge_word());
		end else if (pick < 16) begin
			issue(OP_SETCB, 4'($urandom_range(0, 9)), rreg(), $urandom_range(0, 3) == 0 ? 0 : $urandom);
		end else if (pick < 24) begin
			// callback frame: run, a few ops inside, restore
			issue(OP_RUNCB, 4'($urandom_range(0, 8)), rreg(), $urandom);
			n = $urandom_range(0, 4);
			repeat (n) issue(6'($urandom_range(OP_ADD, OP_NEZ)), rreg(), rreg(), edge_word());
			issue(OP_RESTORE, rreg(), rreg(), $urandom);
		end else if (pick < 30) begin
			issue(OP_CALL, rreg(), rreg(), $urandom);
			issue(OP_RET, rreg(), rreg(), $urandom);
		end else if (pick < 38) begin
			issue($urandom_range(0, 1) ? OP_PUSH : OP_PUSHI, rreg(), rreg(), $urandom);
			issue(OP_POP, rreg(), rreg(), $urandom);
		end else if (pick < 46) begin
			issue(6'($urandom_range(OP_DIV, OP_MODI)), rreg(), rreg(),
				$urandom_range(0, 4) == 0 ? 0 : edge_word());
		end else if (pick < 52) begin
			issue(6'($urandom_range(FIRST_UNDEF_OP, 63)), rreg(), rreg(), $urandom);
		end else begin
			issue(6'($urandom_range(0, OP_FAIL)), rreg(), rreg(), edge_word());
		end
	endtask

	initial begin
		@(posedge clk);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// write every stack word once so no pop ever reads an unwritten entry
		repeat (STACK_WORDS) issue(OP_PUSHI, 4'd0, 4'd0, $urandom);

		// directed corner cases
		issue(OP_SETI, 4'd1, 4'd0, 32'h8000_0000, 3'd6);
		issue(OP_SETI, 4'd2, 4'd0, 32'hFFFF_FFFF, 3'd1);
		issue(OP_DIV, 4'd1, 4'd2, 32'h0);
		issue(OP_SETI, 4'd1, 4'd0, 32'h8000_0000);
		issue(OP_MOD, 4'd1, 4'd2, 32'h0);
		issue(OP_DIV, 4'd2, 4'd0, 32'h0);
		issue(OP_DIVI, 4'd2, 4'd0, 32'h0);
		issue(OP_MODI, 4'd2, 4'd0, 32'h0);
		issue(OP_MULI, 4'd2, 4'd0, 32'h7FFF_FFFF);
		issue(OP_ADDI, 4'd2, 4'd0, 32'hFFFF_FFFF);
		issue(OP_PUSH, CURSOR_REG, 4'd0, 32'h0);
		issue(OP_POP, CURSOR_REG, 4'd0, 32'h0);
		issue(OP_SETCB, 4'd9, 4'd0, 32'h1234);
		issue(OP_RUNCB, 4'd9, 4'd0, 32'h0);
		issue(OP_RUNCB, 4'd3, 4'd0, 32'h0);
		issue(OP_SETCB, 4'd7, 4'd0, 32'hFFFF_FFFF);
		issue(OP_RUNCB, 4'd7, 4'd0, 32'h0);
		issue(OP_RESTORE, 4'd0, 4'd0, 32'h0);
		issue(OP_CALL, 4'd0, 4'd0, 32'hDEAD_BEEF);
		issue(OP_RET, 4'd0, 4'd0, 32'h0);
		issue(OP_JZ, 4'd0, 4'd0, 32'h0000_0100);
		issue(OP_JMPR, 4'd0, 4'd0, 32'hFFFF_FFFF);
		issue(OP_SETFLAG, 4'd0, 4'd0, 32'h0);
		issue(OP_CLRFLAG, 4'd0, 4'd0, 32'h0);
		issue(OP_FAIL, 4'd0, 4'd0, 32'h0);
		issue(6'd63, 4'd15, 4'd15, 32'hFFFF_FFFF);

		while (sent < RANDOM_ITEMS) random_instr();
		in_ch.valid <= 1'b0;

		// let the checker record the last transaction, drain, then settle
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);

		$display("covered %0d instructions (%0d results checked): all opcodes, stack frames,",
			sent, retired);
		$display("callbacks, zero and overflowing division, with input and output stalls");
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	initial begin
		#4_000_000;
		$display("timeout with %0d results outstanding", pending);
		$display("== FAIL ==");
		$finish;
	end

endmodule

// File: script_vm_execute_unit.f
rtl/core/sve_pkg.sv
rtl/core/sve_if.sv
rtl/core/sve_div.sv
rtl/core/sve_dpath.sv
rtl/core/sve_ctrl.sv
rtl/core/script_vm_execute_unit.sv
bench/sve_checker.sv
bench/tb_top.sv
